FILE: rtl/cosine_sum_window_generator_defines.svh
// Assertion macros shared by the window generator RTL.
// Depends on nothing; included inside module bodies that carry assertions.
`ifndef COSINE_SUM_WINDOW_GENERATOR_DEFINES_SVH
`define COSINE_SUM_WINDOW_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CSWG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CSWG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles, disabled during reset
`define CSWG_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

FILE: rtl/cswg_pkg.sv
// Constants, register codes and cosine table builder for the window generator.
// Depends on nothing; imported by cosine_sum_window_generator.
`default_nettype none

package cswg_pkg;

    // Block sizing
    localparam int MAX_LENGTH     = 65536;
    localparam int COS_TABLE_BITS = 10;
    localparam int IDX_W          = 16;
    localparam int LEN_W          = 25;
    localparam int IDX_LAST       = MAX_LENGTH - 1;

    // Configuration port
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 5;
    localparam int REG_IDX_W = 3;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_PHASE_STEP = 3'd0;
    localparam t_reg_idx REG_COEF_DC    = 3'd1;
    localparam t_reg_idx REG_COEF_COS1  = 3'd2;
    localparam t_reg_idx REG_COEF_COS2  = 3'd3;
    localparam t_reg_idx REG_COEF_COS3  = 3'd4;
    localparam t_reg_idx REG_COEF_COS4  = 3'd5;
    localparam t_reg_idx REG_COEF_TRI   = 3'd6;

    localparam logic [DATA_W-1:0] RST_PHASE_STEP = 32'h0000_0000;
    localparam logic [DATA_W-1:0] RST_COEF_DC    = 32'h2000_0000;
    localparam logic [DATA_W-1:0] RST_COEF_COS1  = 32'hE000_0000;
    localparam logic [DATA_W-1:0] RST_COEF_OTHER = 32'h0000_0000;

    // Cosine table: N+1 magnitudes of cos over a quarter turn, Q1.30
    localparam int COS_N     = 1 << COS_TABLE_BITS;
    localparam int ROM_AW    = COS_TABLE_BITS + 1;
    localparam int COS_MAG_W = 31;
    localparam int NUM_HARM  = 4;

    localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

    // Unsigned Q2.62 product, truncated
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // One table entry: Taylor series of cos to the 28th power, rounded to Q1.30
    function automatic logic [COS_MAG_W-1:0] cos_rom_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] c;
        logic [63:0] rnd;
        x    = (HALF_PI_Q62 >> COS_TABLE_BITS) * 64'(i);
        x2   = mul_q62(x, x);
        term = Q62_ONE;
        pos  = Q62_ONE;
        neg  = 64'd0;
        term = mul_q62(term, x2) / 64'd2;   neg = neg + term;
        term = mul_q62(term, x2) / 64'd12;  pos = pos + term;
        term = mul_q62(term, x2) / 64'd30;  neg = neg + term;
        term = mul_q62(term, x2) / 64'd56;  pos = pos + term;
        term = mul_q62(term, x2) / 64'd90;  neg = neg + term;
        term = mul_q62(term, x2) / 64'd132; pos = pos + term;
        term = mul_q62(term, x2) / 64'd182; neg = neg + term;
        term = mul_q62(term, x2) / 64'd240; pos = pos + term;
        term = mul_q62(term, x2) / 64'd306; neg = neg + term;
        term = mul_q62(term, x2) / 64'd380; pos = pos + term;
        term = mul_q62(term, x2) / 64'd462; neg = neg + term;
        term = mul_q62(term, x2) / 64'd552; pos = pos + term;
        term = mul_q62(term, x2) / 64'd650; neg = neg + term;
        term = mul_q62(term, x2) / 64'd756; pos = pos + term;
        c   = (pos > neg) ? (pos - neg) : 64'd0;
        rnd = c + 64'h0000_0000_8000_0000;
        return rnd[32 +: COS_MAG_W];
    endfunction

    // Pipeline depth in register stages, one valid bit per stage
    localparam int LATENCY = 10;

endpackage

`default_nettype wire

FILE: rtl/cosine_sum_window_generator.sv
// Generalized cosine-sum window generator, top level.
// Depends on cswg_pkg and cosine_sum_window_generator_defines.svh.
//
// Usage:
//   Drive start high with i_sample_index to submit one item; busy is always
//   low, so an item is taken at every edge where start is high. Each item
//   yields one window coefficient on o_window_value, marked by o_valid for
//   exactly one cycle; the receiver must take it then.
//   Throughput: one item per clock. The pipeline has ten register stages:
//   index, phase product, phase saturation, table address, cosine table read
//   with triangle product, signed cosine, harmonic products, rounding,
//   partial sums, final sum with saturation.
//   Coefficients and the phase step are written over the APB port; pready is
//   always high, reads return the stored value. Write them only while no
//   item is in flight.
//   Reset (synchronous, active low) empties the pipeline and loads the Hann
//   coefficients with a zero phase step. The cosine table is fixed contents.
`default_nettype none

module cosine_sum_window_generator (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // item channel
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [cswg_pkg::IDX_W-1:0]     i_sample_index,
    output logic                                o_valid,
    output logic signed [cswg_pkg::DATA_W-1:0]  o_window_value,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cswg_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [cswg_pkg::DATA_W-1:0]    pwdata,
    output logic [cswg_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    import cswg_pkg::*;

`include "cosine_sum_window_generator_defines.svh"

    localparam logic signed [63:0] RND_COS = 64'sh0000_0000_2000_0000;
    localparam logic signed [63:0] RND_TRI = 64'sh0000_0000_8000_0000;
    localparam logic signed [35:0] SAT_MAX = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] SAT_MIN = 36'shF_8000_0000;
    localparam logic [47:0]        P_ONE48 = 48'h1_0000_0000;
    localparam logic [32:0]        P_ONE   = 33'h1_0000_0000;
    localparam logic [32:0]        P_HALF  = 33'h0_8000_0000;

    // Configuration registers
    logic [DATA_W-1:0] r_phase_step;
    logic [DATA_W-1:0] r_coef_dc;
    logic [DATA_W-1:0] r_coef_cos1;
    logic [DATA_W-1:0] r_coef_cos2;
    logic [DATA_W-1:0] r_coef_cos3;
    logic [DATA_W-1:0] r_coef_cos4;
    logic [DATA_W-1:0] r_coef_tri;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    // Pipeline valid bits, one per stage
    logic [LATENCY-1:0] r_vld;
    logic               item_take;

    // Stage registers
    logic [IDX_W-1:0]           r_a_idx;
    logic [47:0]                r_b_prod;
    logic [32:0]                r_c_p;
    logic [ROM_AW-1:0]          r_d_addr [NUM_HARM];
    logic [NUM_HARM-1:0]        r_d_neg;
    logic [31:0]                r_d_dist;
    logic [COS_MAG_W-1:0]       r_e_mag [NUM_HARM];
    logic [NUM_HARM-1:0]        r_e_neg;
    logic signed [63:0]         r_e_tri;
    logic signed [31:0]         r_f_cos [NUM_HARM];
    logic signed [32:0]         r_f_tri;
    logic signed [63:0]         r_g_prod [NUM_HARM];
    logic signed [32:0]         r_g_tri;
    logic signed [32:0]         r_h_term [NUM_HARM];
    logic signed [32:0]         r_h_tri;
    logic signed [33:0]         r_i_sum [3];
    logic signed [DATA_W-1:0]   r_j_out;

    // Combinational nets
    logic [IDX_W-1:0]           idx_clamp;
    logic [31:0]                phase [NUM_HARM];
    logic [31:0]                ctr_dist;
    logic signed [DATA_W-1:0]   coef_cos [NUM_HARM];
    logic signed [65:0]         tri_full;
    logic signed [63:0]         tri_rnd;
    logic signed [63:0]         cos_rnd [NUM_HARM];
    logic signed [35:0]         sum_total;
    logic signed [DATA_W-1:0]   sum_sat;

    // Quarter-wave cosine table, two copies with two read ports each
    logic [COS_MAG_W-1:0] cos_rom_a [COS_N+1];
    logic [COS_MAG_W-1:0] cos_rom_b [COS_N+1];

    for (genvar gi = 0; gi <= COS_N; gi++) begin : g_rom
        localparam logic [COS_MAG_W-1:0] ROM_VAL = cos_rom_entry(gi);
        assign cos_rom_a[gi] = ROM_VAL;
        assign cos_rom_b[gi] = ROM_VAL;
    end

    // Handshake outputs
    assign busy      = 1'b0;
    assign pready    = 1'b1;
    assign item_take = start && !busy;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[PADDR_W-1:2];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= RST_PHASE_STEP;
            r_coef_dc    <= RST_COEF_DC;
            r_coef_cos1  <= RST_COEF_COS1;
            r_coef_cos2  <= RST_COEF_OTHER;
            r_coef_cos3  <= RST_COEF_OTHER;
            r_coef_cos4  <= RST_COEF_OTHER;
            r_coef_tri   <= RST_COEF_OTHER;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PHASE_STEP: r_phase_step <= pwdata;
                REG_COEF_DC:    r_coef_dc    <= pwdata;
                REG_COEF_COS1:  r_coef_cos1  <= pwdata;
                REG_COEF_COS2:  r_coef_cos2  <= pwdata;
                REG_COEF_COS3:  r_coef_cos3  <= pwdata;
                REG_COEF_COS4:  r_coef_cos4  <= pwdata;
                REG_COEF_TRI:   r_coef_tri   <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (cfg_idx)
            REG_PHASE_STEP: prdata = r_phase_step;
            REG_COEF_DC:    prdata = r_coef_dc;
            REG_COEF_COS1:  prdata = r_coef_cos1;
            REG_COEF_COS2:  prdata = r_coef_cos2;
            REG_COEF_COS3:  prdata = r_coef_cos3;
            REG_COEF_COS4:  prdata = r_coef_cos4;
            REG_COEF_TRI:   prdata = r_coef_tri;
            default:        prdata = '0;
        endcase
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], item_take};
        end
    end

    // Clamp the index to the last position of the longest window
    always_comb begin
        if ({{(LEN_W-IDX_W){1'b0}}, i_sample_index} > LEN_W'(IDX_LAST)) begin
            idx_clamp = IDX_W'(IDX_LAST);
        end else begin
            idx_clamp = i_sample_index;
        end
    end

    // Harmonic phases (mod one turn) and distance from window center
    always_comb begin
        phase[0] = r_c_p[31:0];
        phase[1] = {r_c_p[30:0], 1'b0};
        phase[2] = r_c_p[31:0] + {r_c_p[30:0], 1'b0};
        phase[3] = {r_c_p[29:0], 2'b00};
        if (r_c_p >= P_HALF) begin
            ctr_dist = 32'(r_c_p - P_HALF);
        end else begin
            ctr_dist = 32'(P_HALF - r_c_p);
        end
    end

    // Coefficient lanes and triangle product
    assign coef_cos[0] = $signed(r_coef_cos1);
    assign coef_cos[1] = $signed(r_coef_cos2);
    assign coef_cos[2] = $signed(r_coef_cos3);
    assign coef_cos[3] = $signed(r_coef_cos4);
    assign tri_full    = $signed({r_coef_tri[31], r_coef_tri}) * $signed({1'b0, r_d_dist});
    assign tri_rnd     = r_e_tri + RND_TRI;

    for (genvar gk = 0; gk < NUM_HARM; gk++) begin : g_rnd
        assign cos_rnd[gk] = r_g_prod[gk] + RND_COS;
    end

    // Final sum and saturation
    always_comb begin
        sum_total = 36'(r_i_sum[0]) + 36'(r_i_sum[1]) + 36'(r_i_sum[2]);
        if (sum_total > SAT_MAX) begin
            sum_sat = SAT_MAX[DATA_W-1:0];
        end else if (sum_total < SAT_MIN) begin
            sum_sat = SAT_MIN[DATA_W-1:0];
        end else begin
            sum_sat = sum_total[DATA_W-1:0];
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        // index
        r_a_idx  <= idx_clamp;
        // phase product
        r_b_prod <= {32'd0, r_a_idx} * {16'd0, r_phase_step};
        // saturate phase at one
        r_c_p    <= (r_b_prod > P_ONE48) ? P_ONE : r_b_prod[32:0];
        // table addresses and signs
        for (int k = 0; k < NUM_HARM; k++) begin
            if (phase[k][30]) begin
                r_d_addr[k] <= ROM_AW'(COS_N) -
                               {1'b0, phase[k][29 -: COS_TABLE_BITS]};
            end else begin
                r_d_addr[k] <= {1'b0, phase[k][29 -: COS_TABLE_BITS]};
            end
            r_d_neg[k] <= phase[k][31] ^ phase[k][30];
        end
        r_d_dist <= ctr_dist;
        // table read and triangle product
        r_e_mag[0] <= cos_rom_a[r_d_addr[0]];
        r_e_mag[1] <= cos_rom_a[r_d_addr[1]];
        r_e_mag[2] <= cos_rom_b[r_d_addr[2]];
        r_e_mag[3] <= cos_rom_b[r_d_addr[3]];
        r_e_neg    <= r_d_neg;
        r_e_tri    <= tri_full[63:0];
        // signed cosine, round triangle term
        for (int k = 0; k < NUM_HARM; k++) begin
            r_f_cos[k] <= r_e_neg[k] ? -$signed({1'b0, r_e_mag[k]})
                                     :  $signed({1'b0, r_e_mag[k]});
        end
        r_f_tri <= {tri_rnd[63], tri_rnd[63:32]};
        // harmonic products
        for (int k = 0; k < NUM_HARM; k++) begin
            r_g_prod[k] <= coef_cos[k] * r_f_cos[k];
        end
        r_g_tri <= r_f_tri;
        // round harmonic terms
        for (int k = 0; k < NUM_HARM; k++) begin
            r_h_term[k] <= cos_rnd[k][62:30];
        end
        r_h_tri <= r_g_tri;
        // partial sums
        r_i_sum[0] <= 34'($signed(r_coef_dc)) + 34'(r_h_tri);
        r_i_sum[1] <= 34'(r_h_term[0]) + 34'(r_h_term[1]);
        r_i_sum[2] <= 34'(r_h_term[2]) + 34'(r_h_term[3]);
        // result
        r_j_out <= sum_sat;
    end

    assign o_valid        = r_vld[LATENCY-1];
    assign o_window_value = r_j_out;

    // Every taken item yields one result after the pipeline depth
    `CSWG_ASSERT_DLY(a_item_result, i_clk, i_rst_n, item_take, LATENCY, o_valid,
                     "item taken without a result at the pipeline depth")
    // No result without an item taken at the pipeline depth before
    `CSWG_ASSERT_IMP(a_no_phantom, i_clk, i_rst_n, o_valid, $past(item_take, LATENCY),
                     "result without a matching item")
    // Phase saturates at one full turn
    `CSWG_ASSERT_NXT(a_phase_sat, i_clk, i_rst_n, r_vld[1] && (r_b_prod > P_ONE48),
                     r_c_p == P_ONE, "phase not saturated at one")
    // Positive overflow of the sum clips to the largest value
    `CSWG_ASSERT_NXT(a_sum_sat, i_clk, i_rst_n, r_vld[LATENCY-2] && (sum_total > SAT_MAX),
                     o_window_value == SAT_MAX[DATA_W-1:0], "sum not saturated")

endmodule

`default_nettype wire

FILE: bench/tb_cosine_sum_window_generator.sv
// Self-checking testbench for cosine_sum_window_generator: random sample indices under
// preset, extreme and random coefficient settings, checked against an in-bench window model.
// Depends on cswg_pkg and the cosine_sum_window_generator RTL.

module tb_cosine_sum_window_generator;

    import cswg_pkg::*;

    localparam t_reg_idx REG_SPARE   = 3'd7;
    localparam int       NUM_REGS    = 7;
    localparam int       STALL_LIMIT = 2000;
    localparam int       ITEM_TARGET = 650;

    typedef logic [NUM_REGS-1:0][DATA_W-1:0] window_regs_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [IDX_W-1:0]    i_sample_index = '0;
    logic                o_valid;
    logic [DATA_W-1:0]   o_window_value;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Shadow of the configuration registers and the quarter-wave cosine magnitudes
    window_regs_t        win_regs;
    int                  cos_mag [0:COS_N];

    logic [IDX_W-1:0]    pending_index_q [$];
    logic [DATA_W-1:0]   window_due_q [$];

    int                  gap_left = 0;
    bit                  dense_mode = 1'b0;
    int                  idle_cycles = 0;
    int                  err_count = 0;
    int                  items_queued = 0;
    int                  items_taken = 0;
    int                  results_seen = 0;
    int                  settings_used = 0;

    cosine_sum_window_generator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample_index (i_sample_index),
        .o_valid        (o_valid),
        .o_window_value (o_window_value),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Unsigned Q2.62 product, truncated to 64 bits
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] wide;
        wide = 128'(a) * 128'(b);
        return wide[125:62];
    endfunction

    // Cosine magnitude at i/N of a quarter turn: Taylor series, rounded to Q1.30
    function automatic int cos_entry(input int i);
        logic [63:0] arg;
        logic [63:0] arg_sq;
        logic [63:0] term;
        logic [63:0] even_sum;
        logic [63:0] odd_sum;
        logic [63:0] mag;
        int k;
        arg      = (HALF_PI_Q62 >> COS_TABLE_BITS) * 64'(i);
        arg_sq   = q62_mul(arg, arg);
        term     = Q62_ONE;
        even_sum = Q62_ONE;
        odd_sum  = '0;
        for (k = 1; k <= 14; k++) begin
            term = q62_mul(term, arg_sq) / 64'((2 * k - 1) * (2 * k));
            if (k[0])
                odd_sum = odd_sum + term;
            else
                even_sum = even_sum + term;
        end
        mag = (even_sum > odd_sum) ? even_sum - odd_sum : '0;
        mag = (mag + 64'h8000_0000) >> 32;
        return int'(mag[31:0]);
    endfunction

    function automatic longint as_q30(input logic [DATA_W-1:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Signed cosine of a phase given as a fraction of a full turn
    function automatic longint cos_at(input logic [31:0] ph);
        logic [COS_TABLE_BITS-1:0] r;
        r = ph[29 -: COS_TABLE_BITS];
        case (ph[31:30])
            2'd0:    return longint'(cos_mag[r]);
            2'd1:    return -longint'(cos_mag[COS_N - r]);
            2'd2:    return -longint'(cos_mag[r]);
            default: return longint'(cos_mag[COS_N - r]);
        endcase
    endfunction

    // Window coefficient for one sample index under the current shadow registers
    function automatic logic [DATA_W-1:0] window_at(input logic [IDX_W-1:0] idx);
        logic [47:0] pos;
        logic [47:0] harm;
        logic [31:0] center_off;
        longint acc;
        int k;
        pos = 48'(idx) * 48'(win_regs[REG_PHASE_STEP]);
        if (pos > 48'h1_0000_0000)
            pos = 48'h1_0000_0000;
        center_off = (pos >= 48'h8000_0000) ? 32'(pos - 48'h8000_0000)
                                            : 32'(48'h8000_0000 - pos);
        acc = as_q30(win_regs[REG_COEF_DC]);
        acc += round_half_up(as_q30(win_regs[REG_COEF_TRI]) * longint'({32'd0, center_off}), 32);
        for (k = 1; k <= NUM_HARM; k++) begin
            harm = pos * 48'(k);
            acc += round_half_up(as_q30(win_regs[REG_COEF_COS1 + k - 1]) * cos_at(harm[31:0]), 30);
        end
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        else if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    function automatic logic [DATA_W-1:0] q30(input real x);
        return DATA_W'($rtoi((x >= 0.0) ? x * 1073741824.0 + 0.5 : x * 1073741824.0 - 0.5));
    endfunction

    function automatic logic [DATA_W-1:0] step_for(input int len);
        return DATA_W'(64'h1_0000_0000 / 64'(len - 1));
    endfunction

    // Window length that a phase step stands for, capped at the index range
    function automatic int len_of(input logic [DATA_W-1:0] step);
        logic [63:0] n;
        if (step == '0)
            return MAX_LENGTH;
        n = 64'h1_0000_0000 / 64'(step) + 64'd1;
        return (n > 64'(MAX_LENGTH)) ? MAX_LENGTH : int'(n);
    endfunction

    function automatic window_regs_t preset(input int len, input real a0, input real a1,
                                            input real a2, input real a3, input real a4,
                                            input real slope);
        window_regs_t w;
        w[REG_PHASE_STEP] = step_for(len);
        w[REG_COEF_DC]    = q30(a0);
        w[REG_COEF_COS1]  = q30(a1);
        w[REG_COEF_COS2]  = q30(a2);
        w[REG_COEF_COS3]  = q30(a3);
        w[REG_COEF_COS4]  = q30(a4);
        w[REG_COEF_TRI]   = q30(slope);
        return w;
    endfunction

    // Random setting: real window lengths half the time, else odd steps; mixed coefficient sizes
    function automatic window_regs_t random_regs();
        window_regs_t w;
        int i;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w[REG_PHASE_STEP] = step_for($urandom_range(3, 300));
            4:          w[REG_PHASE_STEP] = step_for($urandom_range(301, MAX_LENGTH));
            5:          w[REG_PHASE_STEP] = '0;
            6:          w[REG_PHASE_STEP] = 32'h8000_0000;
            7:          w[REG_PHASE_STEP] = $urandom_range(1, 64);
            default:    w[REG_PHASE_STEP] = $urandom_range(0, 32'h8000_0000);
        endcase
        for (i = REG_COEF_DC; i <= REG_COEF_TRI; i++) begin
            if ($urandom_range(0, 1) != 0)
                w[i] = $urandom;
            else
                w[i] = DATA_W'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
        end
        return w;
    endfunction

    // Idle length after an item: mostly short, a few long, none in dense phases
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (dense_mode || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    task automatic note_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        $display("ERROR %s: got %h, expected %h", what, got, want);
        err_count++;
    endtask

    task automatic cfg_write(input t_reg_idx r, input logic [DATA_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (r <= REG_COEF_TRI)
            win_regs[r] = v;
    endtask

    // Read back every register and compare with the shadow copy
    task automatic check_all_regs();
        int i;
        for (i = REG_PHASE_STEP; i <= REG_COEF_TRI; i++) begin
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {t_reg_idx'(i), 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            @(negedge i_clk);
            while (!pready) @(negedge i_clk);
            if (prdata !== win_regs[i])
                note_mismatch($sformatf("register %0d readback", i), prdata, win_regs[i]);
            @(posedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic apply_cfg(input window_regs_t w);
        int i;
        for (i = REG_PHASE_STEP; i <= REG_COEF_TRI; i++)
            cfg_write(t_reg_idx'(i), w[i]);
        check_all_regs();
        settings_used++;
    endtask

    // Append one sample index to the pending queue
    task automatic enqueue_index(input logic [IDX_W-1:0] idx);
        pending_index_q.insert(pending_index_q.size(), idx);
    endtask

    // Queue a sweep of the window for some short lengths, then random indices mostly around it
    task automatic push_items(input int len, input int count);
        int n;
        int hi;
        hi = (len + 3 > IDX_LAST) ? IDX_LAST : len + 3;
        if (len <= 48 && $urandom_range(0, 2) != 0) begin
            for (n = 0; n < len; n++)
                enqueue_index(IDX_W'(n));
            items_queued += len;
        end
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) < 7)
                enqueue_index(IDX_W'($urandom_range(0, hi)));
            else
                enqueue_index(IDX_W'($urandom));
        end
        items_queued += count;
    endtask

    // Hold until every queued item is taken and every result is back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_index_q.size() != 0 || start || window_due_q.size() != 0);
    endtask

    // Offer queued items, hold an offer while busy, insert random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (!(start && busy)) begin
            if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_index_q.size() > 0) begin
                start          <= 1'b1;
                i_sample_index <= pending_index_q.pop_front();
                gap_left       <= next_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Check each result against the oldest prediction, then record new items
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                results_seen++;
                if (window_due_q.size() == 0)
                    note_mismatch("window value with no item in flight", o_window_value, '0);
                else if (o_window_value !== window_due_q[0])
                    note_mismatch("window value", o_window_value, window_due_q.pop_front());
                else
                    void'(window_due_q.pop_front());
            end
            if (start && !busy) begin
                window_due_q.insert(window_due_q.size(), window_at(i_sample_index));
                items_taken++;
            end
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("cosine_sum_window_generator: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        window_regs_t shapes [0:11];
        int i;

        for (i = 0; i <= COS_N; i++)
            cos_mag[i] = cos_entry(i);
        win_regs[REG_PHASE_STEP] = RST_PHASE_STEP;
        win_regs[REG_COEF_DC]    = RST_COEF_DC;
        win_regs[REG_COEF_COS1]  = RST_COEF_COS1;
        win_regs[REG_COEF_COS2]  = RST_COEF_OTHER;
        win_regs[REG_COEF_COS3]  = RST_COEF_OTHER;
        win_regs[REG_COEF_COS4]  = RST_COEF_OTHER;
        win_regs[REG_COEF_TRI]   = RST_COEF_OTHER;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values, zero step: every index sits at the window start
        check_all_regs();
        enqueue_index(16'h0000);
        enqueue_index(16'hFFFF);
        enqueue_index(16'h5555);
        enqueue_index(16'hAAAA);
        enqueue_index(16'h8000);
        items_queued += 5;
        wait_idle();

        // Write to the unused register index must leave the others alone
        cfg_write(REG_SPARE, $urandom);
        check_all_regs();

        // Hann over 16 points, walk the window and run past its end
        apply_cfg(preset(16, 0.5, -0.5, 0.0, 0.0, 0.0, 0.0));
        for (i = 0; i < 16; i++)
            enqueue_index(IDX_W'(i));
        enqueue_index(16'd16);
        enqueue_index(16'hFFFF);
        items_queued += 18;
        wait_idle();

        // Stock windows, then both coefficient extremes
        shapes[0]  = preset(64, 0.53836, -0.46164, 0.0, 0.0, 0.0, 0.0);
        shapes[1]  = preset(50, 0.42659, -0.49656, 0.076849, 0.0, 0.0, 0.0);
        shapes[2]  = preset(33, 0.35875, -0.48829, 0.14128, -0.01168, 0.0, 0.0);
        shapes[3]  = preset(100, 0.3635819, -0.4891775, 0.1365995, -0.0106411, 0.0, 0.0);
        shapes[4]  = preset(128, 0.355768, -0.487396, 0.144232, -0.012604, 0.0, 0.0);
        shapes[5]  = preset(25, 0.21557895, -0.41663158, 0.277263158, -0.083578947,
                            0.006947368, 0.0);
        shapes[6]  = preset(1024, 0.402, -0.498, 0.098, -0.001, 0.0, 0.0);
        shapes[7]  = preset(17, 1.0, 0.0, 0.0, 0.0, 0.0, -2.0);
        shapes[8]  = preset(40, 0.62, -0.38, 0.0, 0.0, 0.0, -0.48);
        shapes[9]  = preset(3, 1.0, 0.0, 0.0, 0.0, 0.0, 0.0);
        shapes[10] = {NUM_REGS{32'h7FFF_FFFF}};
        shapes[10][REG_PHASE_STEP] = 32'h0000_0001;
        shapes[11] = {NUM_REGS{32'h8000_0000}};
        for (i = 0; i < 12; i++) begin
            dense_mode = ($urandom_range(0, 3) == 0);
            apply_cfg(shapes[i]);
            push_items(len_of(shapes[i][REG_PHASE_STEP]), $urandom_range(20, 40));
            wait_idle();
        end

        // Random settings until the item budget is spent
        while (items_queued < ITEM_TARGET) begin
            dense_mode = ($urandom_range(0, 3) == 0);
            shapes[0] = random_regs();
            apply_cfg(shapes[0]);
            push_items(len_of(shapes[0][REG_PHASE_STEP]), $urandom_range(30, 60));
            wait_idle();
        end

        // Let any stray result surface before the verdict
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("covered %0d sample indices and %0d window values under %0d register settings",
                 items_taken, results_seen, settings_used);
        if (err_count == 0) begin
            $display("cosine_sum_window_generator: match");
        end else begin
            $display("%0d errors found", err_count);
            $display("cosine_sum_window_generator: mismatch");
        end
        $finish;
    end

endmodule
